// ----- sv/scl_pkg.sv -----
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types and character codes for the serial command line parser.
// ----------------------------------------------------------------------------
package scl_pkg;

  // Character codes
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_VT    = 8'd11;
  localparam logic [7:0] CHAR_FF    = 8'd12;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  // Magnitude limits
  localparam logic [31:0] MAG_LIMIT   = 32'h8000_0000;
  localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] ACC_LIM_LO  = 32'd214748364;  // digits 0..8
  localparam logic [31:0] ACC_LIM_HI9 = 32'd214748363;  // digit 9

  // Number phase of the current line
  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,   // skipping leading whitespace
    PH_DIGITS = 2'd1,   // after a sign or a digit
    PH_DONE   = 2'd2    // number finished
  } phase_t;

  // Completed line
  typedef struct packed {
    logic [6:0]         cmd;
    logic signed [31:0] value;
  } res_t;

  // Whitespace skipped before the number
  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
  endfunction

endpackage

// ----- sv/scl_parse.sv -----
// ----------------------------------------------------------------------------
// scl_parse
// Line state and per-byte update: command letter, sign, saturated magnitude.
// ----------------------------------------------------------------------------
module scl_parse
  import scl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_go,
  input  logic [7:0] rx_byte,
  output logic       res_vld,
  output res_t       res
);

  logic        line_r, line_nxt;
  logic [6:0]  cmd_r, cmd_nxt;
  phase_t      phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] acc_r, acc_nxt;

  logic        used;
  logic        digit;
  logic [3:0]  dval;
  logic [34:0] times10;
  logic        sat;
  logic [31:0] acc_step;

  // Byte classification
  assign used  = (rx_byte != 8'd0) && !rx_byte[7] && (rx_byte != CHAR_LF);
  assign digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
  assign dval  = rx_byte[3:0];

  // acc*10 + d, saturating at 2^31
  assign times10  = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + {31'd0, dval};
  assign sat      = (dval == 4'd9) ? (acc_r > ACC_LIM_HI9) : (acc_r > ACC_LIM_LO);
  assign acc_step = sat ? MAG_LIMIT : times10[31:0];

  // Signed result from the current line
  always_comb begin
    res.cmd = cmd_r;
    if (neg_r) begin
      res.value = 32'd0 - acc_r;
    end else begin
      res.value = acc_r[31] ? POS_MAX : acc_r;
    end
  end

  // Next line state
  always_comb begin
    line_nxt  = line_r;
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    res_vld   = 1'b0;
    if (byte_go && used) begin
      if (rx_byte == CHAR_CR) begin
        if (line_r) begin
          res_vld   = 1'b1;
          line_nxt  = 1'b0;
          cmd_nxt   = 7'd0;
          phase_nxt = PH_SKIP;
          neg_nxt   = 1'b0;
          acc_nxt   = 32'd0;
        end
      end else if (!line_r) begin
        line_nxt = 1'b1;
        cmd_nxt  = rx_byte[6:0];
      end else begin
        unique case (phase_r)
          PH_SKIP: begin
            if (is_blank(rx_byte)) begin
              phase_nxt = PH_SKIP;
            end else if ((rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS)) begin
              neg_nxt   = (rx_byte == CHAR_MINUS);
              phase_nxt = PH_DIGITS;
            end else if (digit) begin
              acc_nxt   = acc_step;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (digit) begin
              acc_nxt = acc_step;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE: begin
            phase_nxt = PH_DONE;
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r  <= 1'b0;
      cmd_r   <= 7'd0;
      phase_r <= PH_SKIP;
      neg_r   <= 1'b0;
      acc_r   <= 32'd0;
    end else begin
      line_r  <= line_nxt;
      cmd_r   <= cmd_nxt;
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

// ----- sv/scl_out_reg.sv -----
// ----------------------------------------------------------------------------
// scl_out_reg
// Result register: holds one completed line until the receiver takes it.
// ----------------------------------------------------------------------------
module scl_out_reg
  import scl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic        res_vld,
  input  res_t        res,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [6:0]  out_command_char,
  output logic signed [31:0] out_number_value
);

  logic vld_r, vld_nxt;
  res_t res_r;

  // A load happens only when the register is empty or being drained
  assign vld_nxt = load ? res_vld : (vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid        = vld_r;
  assign out_command_char = res_r.cmd;
  assign out_number_value = res_r.value;

endmodule

// ----- sv/serial_command_line_parser_top.sv -----
// ----------------------------------------------------------------------------
// serial_command_line_parser_top
// Serial command line parser: <letter><decimal value><CR> lines to results.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and sustains one byte per clock cycle while
// no result waits under stall. A byte goes into an input register, is folded
// into the line state once the result register has room, and a carriage return
// on a non-empty line puts the command letter and the saturated signed value
// into the result register, from which the result is shown. The clock period
// is set by the multiply-by-ten-and-add with its saturation compare in the
// parse stage. A result waiting under stall does not hold up input at once:
// the input register takes one more byte, and only then is stall raised on the
// input side.
// ----------------------------------------------------------------------------
module serial_command_line_parser_top
  import scl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_command_char,
  output logic signed [31:0] out_number_value
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       go;
  logic       res_vld;
  res_t       res;

  // Parse when a byte is held and the result register has room
  assign go       = in_vld_r && (!out_valid || !out_stall);
  assign in_stall = in_vld_r && !go;

  // Input register
  assign in_vld_nxt = (in_valid && !in_stall) ? 1'b1 : (go ? 1'b0 : in_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  scl_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_go (go),
    .rx_byte (in_byte_r),
    .res_vld (res_vld),
    .res     (res)
  );

  scl_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (go),
    .res_vld          (res_vld),
    .res              (res),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_command_char (out_command_char),
    .out_number_value (out_number_value)
  );

endmodule

// ----- sv/scl_checker.sv -----
// ----------------------------------------------------------------------------
// scl_checker
// Port-level checks on the serial command line parser.
// ----------------------------------------------------------------------------
module scl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  out_command_char,
  input logic signed [31:0] out_number_value
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // A result always carries a real command letter
  a_cmd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_command_char != 7'd0))
    else $error("result with empty command letter");

  // With no result waiting the input side never stalls
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_command_char) && $stable(out_number_value)))
    else $error("stalled result beat changed");

  // A stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_rx_byte)))
    else $error("stalled input beat changed");

endmodule

bind serial_command_line_parser_top scl_checker u_scl_checker (.*);

// ----- dv/scl_scoreboard_pkg.sv -----
// ----------------------------------------------------------------------------
// scl_scoreboard_pkg
// Line predictor and result scoreboard for the serial command line parser.
// ----------------------------------------------------------------------------
// Keeps its own copy of the line state. Each accepted byte is folded into it,
// and a carriage return on a non-empty line queues the expected command and
// value. Results from the block are compared against the oldest entry.
// ----------------------------------------------------------------------------
package scl_scoreboard_pkg;
  import scl_pkg::*;

  class command_line_scoreboard;
    // Line state
    logic       line_open;
    logic [6:0] letter;
    phase_t     num_state;
    logic       negative;
    logic [31:0] magnitude;

    res_t        expected_lines[$];
    int unsigned mismatches;

    function new();
      clear_line();
      mismatches = 0;
    endfunction

    function void clear_line();
      line_open = 1'b0;
      letter    = '0;
      num_state = PH_SKIP;
      negative  = 1'b0;
      magnitude = '0;
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    // Whitespace that may precede the sign or first digit
    function logic blank_byte(logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
    endfunction

    // Magnitude times ten plus digit, held at 2^31 once it gets there
    function void add_digit(logic [7:0] c);
      logic [35:0] wide;
      wide = 36'(magnitude) * 36'd10 + 36'(c - CHAR_ZERO);
      magnitude = (wide > 36'(MAG_LIMIT)) ? MAG_LIMIT : wide[31:0];
    endfunction

    // Fold one accepted beat into the line
    function void note_byte(logic [7:0] c);
      res_t line;
      logic is_digit;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      // unused bytes and line feed leave everything alone
      if (c == 8'd0 || c[7] || c == CHAR_LF) return;
      if (c == CHAR_CR) begin
        if (!line_open) return;
        line.cmd = letter;
        if (negative) line.value = 32'(32'd0 - magnitude);
        else line.value = (magnitude > POS_MAX) ? POS_MAX : magnitude;
        expected_lines.push_back(line);
        clear_line();
        return;
      end
      if (!line_open) begin
        line_open = 1'b1;
        letter    = c[6:0];
        return;
      end
      case (num_state)
        PH_SKIP: begin
          if (blank_byte(c)) return;
          if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            negative  = (c == CHAR_MINUS);
            num_state = PH_DIGITS;
          end else if (is_digit) begin
            add_digit(c);
            num_state = PH_DIGITS;
          end else begin
            num_state = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) add_digit(c);
          else num_state = PH_DONE;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    // Compare one accepted result beat with the oldest expected line
    task check_line(logic [6:0] cmd, logic signed [31:0] value);
      res_t want;
      if (expected_lines.size() == 0) begin
        report($sformatf("unexpected line cmd=%0d value=%0d", cmd, value));
        return;
      end
      want = expected_lines.pop_front();
      if (cmd !== want.cmd)
        report($sformatf("command %0d, expected %0d", cmd, want.cmd));
      if (value !== want.value)
        report($sformatf("value %0d, expected %0d (cmd %0d)", value, want.value, want.cmd));
    endtask
  endclass

endpackage

// ----- dv/serial_command_line_parser_top_tb.sv -----
// ----------------------------------------------------------------------------
// serial_command_line_parser_top_tb
// Self-checking bench for the serial command line parser.
// ----------------------------------------------------------------------------
// Sends a short directed set of lines covering unused bytes, line feeds, empty
// lines, sign without digits, trailing garbage and saturation, then random
// lines, mostly well formed, with noise mixed in. Sender and receiver idle at
// random in the first two of three phases, and in the third the receiver holds
// off for a long stretch once so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module serial_command_line_parser_top_tb;
  import scl_pkg::*;
  import scl_scoreboard_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BYTES = 350;
  localparam int unsigned HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_command_char;
  logic signed [31:0] out_number_value;

  command_line_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned used_bytes = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  line_bytes[$];

  // Directed lines
  logic [7:0] directed_bytes[] = '{
    8'h00, 8'hFF, 8'h80, CHAR_CR, CHAR_LF,
    8'h01, CHAR_CR,
    8'h7F, CHAR_TAB, CHAR_PLUS, CHAR_CR,
    "c", "1", CHAR_LF, "2", "z", "9", CHAR_CR,
    "d", CHAR_SPACE, CHAR_MINUS, "3", "0", "0", "0", "0", "0", "0", "0", "0", "0",
    CHAR_CR
  };

  serial_command_line_parser_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command_char (out_command_char),
    .out_number_value (out_number_value)
  );

  always #1 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    int unsigned hold_left;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_line(out_command_char, out_number_value);
  end

  // One input beat; called and returns at a falling edge
  task send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    if (b != 8'd0 && !b[7] && b != CHAR_LF) used_bytes++;
    @(negedge clk);
  endtask

  // Decimal digits of a value, with the odd leading zero
  function void add_number(logic [63:0] num);
    logic [7:0] digs[$];
    do begin
      digs.push_front(8'(CHAR_ZERO + num % 10));
      num = num / 10;
    end while (num != 0);
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3)) digs.push_front(CHAR_ZERO);
    foreach (digs[i]) line_bytes.push_back(digs[i]);
  endfunction

  // Build one random line into line_bytes
  function void build_line();
    int unsigned kind;
    logic [7:0]  c;
    logic [63:0] num;
    line_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 8) begin
      // raw noise, any byte value
      repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom));
      return;
    end
    if (kind < 11) begin
      line_bytes.push_back(CHAR_CR);
      return;
    end
    // command letter
    do c = 8'($urandom_range(1, 127)); while (c == CHAR_CR || c == CHAR_LF);
    line_bytes.push_back(c);
    // leading whitespace
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(3))
        0: line_bytes.push_back(CHAR_SPACE);
        1: line_bytes.push_back(CHAR_TAB);
        2: line_bytes.push_back(CHAR_VT);
        default: line_bytes.push_back(CHAR_FF);
      endcase
    end
    // optional sign
    case ($urandom_range(2))
      0: line_bytes.push_back(CHAR_PLUS);
      1: line_bytes.push_back(CHAR_MINUS);
      default: ;
    endcase
    // digits: none, boundary values, or random sizes
    kind = $urandom_range(99);
    if (kind >= 10) begin
      if (kind < 30) begin
        case ($urandom_range(7))
          0: num = 64'd0;
          1: num = 64'd2147483646;
          2: num = 64'd2147483647;
          3: num = 64'd2147483648;
          4: num = 64'd2147483649;
          5: num = 64'd4294967295;
          6: num = 64'd10000000000;
          default: num = 64'd99999999999;
        endcase
      end else if (kind < 40) begin
        num = {32'($urandom), 32'($urandom)} >> $urandom_range(63);
      end else begin
        num = 64'($urandom) >> $urandom_range(31);
      end
      add_number(num);
    end
    // trailing garbage, whitespace included
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        do c = 8'($urandom_range(1, 127)); while (c == CHAR_CR);
        line_bytes.push_back(c);
      end
    end
    // stray line feeds and unused bytes inside the line
    if ($urandom_range(9) == 0)
      line_bytes.insert($urandom_range(line_bytes.size()), CHAR_LF);
    if ($urandom_range(19) == 0)
      line_bytes.insert($urandom_range(line_bytes.size()),
                        ($urandom_range(1) != 0) ? 8'h00 : 8'($urandom_range(128, 255)));
    line_bytes.push_back(CHAR_CR);
  endfunction

  // Main sequence
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = HOLD_CYCLES;
        end
      endcase
      while (used_bytes < (ph + 1) * PHASE_BYTES) begin
        build_line();
        foreach (line_bytes[i]) send_byte(line_bytes[i]);
      end
    end
    in_valid <= 1'b0;

    // drain, then allow for the pipeline
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
